@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ltcl_pkg.sv @@
`timescale 1ns / 1ps

package ltcl_pkg;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 3;
    localparam int OUT_W   = 104;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // One stored line: key as first presented, and its last access stamp
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Fold ASCII upper case letters to lower case, byte by byte
    function automatic logic [KEY_W-1:0] fold_case(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = '0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            b = k[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A) begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

@@ hdl/ltcl_ram.sv @@
`timescale 1ns / 1ps

module ltcl_ram #(
    parameter int DEPTH = 5,
    parameter int AW    = 3
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ltcl_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output ltcl_pkg::entry_t    rd_data
);
    import ltcl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read: data appears in the cycle after rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lru_tag_cache_lookup_core.sv @@
`timescale 1ns / 1ps
// Fully associative key cache, least-recently-used replacement by stamps.
// Input channel s_axis: one 64-bit key per item, compared with ASCII case
// folded. Result channel m_axis: one item per key with hit, slot, the
// access stamp written, and the evicted key when a full cache replaced one.
// Each key is handled alone: the next key is taken only after the previous
// one has been written back and its result loaded into the output register;
// the stored lines are read one per cycle from a synchronous RAM, followed
// by a write-back.
// The result sits in an output register; a new key is accepted while it waits.
// If the receiver stalls, the block finishes the next lookup and then holds in
// write-back until the output register frees.
// Reset (aresetn low, synchronous) empties the cache and clears the access
// counter; RAM contents are not cleared, as only filled slots are ever read.
// The access counter saturates at all ones.

`include "assert_macros.svh"

module lru_tag_cache_lookup_core #(
    parameter int ENTRIES   = 5,
    parameter int KEY_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // key[63:0]
    input  logic [63:0]  s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // hit[0], slot[3:1], stamp[35:4], evicted[36], evicted_key[100:37], pad
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);
    import ltcl_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [KEY_W-1:0]   hit_key_reg, hit_key_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   fold_reg, fold_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic               accept;
    logic               full;
    logic               out_free;
    logic [IDX_W-1:0]   slot_sel;
    logic               mem_we;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;
    logic [KEY_W-1:0]   key_in;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key_in        = s_axis_tdata & KEY_MASK;
    assign full          = (filled_reg == FULL_CNT);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Line store
    ltcl_ram #(
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (slot_sel),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Read issue: slot 0 on acceptance, then one slot a cycle up to the fill count
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (accept) begin
            mem_re = (filled_reg != '0);
        end else if (state_reg == ST_SCAN && issue_idx_reg < filled_reg) begin
            mem_re    = 1'b1;
            mem_raddr = issue_idx_reg[IDX_W-1:0];
        end
    end

    // Slot chosen for write-back: hit, next free, or least recently used
    always_comb begin
        if (hit_found_reg) begin
            slot_sel = hit_idx_reg;
        end else if (!full) begin
            slot_sel = filled_reg[IDX_W-1:0];
        end else begin
            slot_sel = best_idx_reg;
        end
    end

    assign mem_we          = (state_reg == ST_FINISH);
    assign mem_wdata.key   = hit_found_reg ? hit_key_reg : key_reg;
    assign mem_wdata.stamp = counter_reg;

    // Controller and scan datapath
    always_comb begin
        state_next      = state_reg;
        issue_idx_next  = issue_idx_reg;
        rvalid_next     = mem_re;
        ridx_next       = mem_raddr;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_key_next    = hit_key_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        best_key_next   = best_key_reg;
        key_next        = key_reg;
        fold_next       = fold_reg;
        counter_next    = counter_reg;
        filled_next     = filled_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next       = key_in;
                    fold_next      = fold_case(key_in);
                    hit_found_next = 1'b0;
                    issue_idx_next = CNT_W'(1);
                    if (counter_reg != STAMP_MAX) begin
                        counter_next = counter_reg + STAMP_W'(1);
                    end
                    state_next = (filled_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (mem_re) begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (rvalid_reg) begin
                    // first matching slot wins
                    if (!hit_found_reg && fold_case(mem_rdata.key) == fold_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = ridx_reg;
                        hit_key_next   = mem_rdata.key;
                    end
                    // strict compare keeps the lowest slot on equal stamps
                    if (ridx_reg == '0 || mem_rdata.stamp < best_stamp_reg) begin
                        best_stamp_next = mem_rdata.stamp;
                        best_idx_next   = ridx_reg;
                        best_key_next   = mem_rdata.key;
                    end
                    if (issue_idx_reg == filled_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // write-back repeats harmlessly while the output is blocked
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000,
                                      (!hit_found_reg && full) ? best_key_reg : '0,
                                      !hit_found_reg && full,
                                      counter_reg,
                                      SLOT_W'(slot_sel),
                                      hit_found_reg};
                    if (!hit_found_reg && !full) begin
                        filled_next = filled_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rvalid_reg    <= 1'b0;
            counter_reg   <= '0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            counter_reg   <= counter_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        issue_idx_reg  <= issue_idx_next;
        ridx_reg       <= ridx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_key_reg    <= hit_key_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        best_key_reg   <= best_key_next;
        key_reg        <= key_next;
        fold_reg       <= fold_next;
        out_data_reg   <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    `ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, filled_reg <= FULL_CNT,
                 "fill count beyond capacity")
    `ASSERT_IMPL(a_evict_miss, aclk, aresetn, out_valid_reg && out_data_reg[36],
                 !out_data_reg[0], "eviction reported on a hit")
    `ASSERT_NEXT(a_stamp_out, aclk, aresetn, state_reg == ST_FINISH && out_free,
                 out_data_reg[35:4] == counter_reg, "result stamp differs from counter")
    `ASSERT_NEXT(a_counter_run, aclk, aresetn, accept, counter_reg != '0,
                 "counter did not advance")

endmodule
